// ----- hdl/tolp_pkg.sv -----
`timescale 1ns / 1ps

package tolp_pkg;

    // line buffer size, including room for the terminating zero
    localparam int LINE_MAX = 128;
    localparam int CNT_W    = $clog2(LINE_MAX);
    localparam int POS_W    = 7;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_MAX - 1);

    localparam logic [7:0] CODE_IAC  = 8'd255;
    localparam logic [7:0] CODE_DONT = 8'd254;
    localparam logic [7:0] CODE_DO   = 8'd253;
    localparam logic [7:0] CODE_WONT = 8'd252;
    localparam logic [7:0] CODE_WILL = 8'd251;
    localparam logic [7:0] CODE_CR   = 8'd13;
    localparam logic [7:0] CODE_LF   = 8'd10;
    localparam logic [7:0] CODE_NUL  = 8'd0;

    localparam logic VERB_DONT = 1'b0;
    localparam logic VERB_WONT = 1'b1;

    localparam logic [7:0] CFG_OPTION_A = 8'd0;
    localparam logic [7:0] CFG_OPTION_B = 8'd1;

    localparam logic [7:0] OPTION_A_RESET = 8'd3;
    localparam logic [7:0] OPTION_B_RESET = 8'd1;

    localparam int TDATA_W = 32;

    typedef enum logic [2:0] {
        ST_NORMAL = 3'd0,
        ST_IAC    = 3'd1,
        ST_WILL   = 3'd2,
        ST_WONT   = 3'd3,
        ST_DO     = 3'd4,
        ST_DONT   = 3'd5
    } t_parse_state;

    typedef struct packed {
        logic             line_overflow;
        logic             line_end;
        logic [POS_W-1:0] char_position;
        logic [7:0]       char_value;
        logic             char_valid;
        logic [7:0]       reply_option;
        logic             reply_verb;
        logic             reply_valid;
    } t_result;

    // line index as carried on the output, low bits of the count
    function automatic logic [POS_W-1:0] pos_of(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+POS_W-1:0] ext;
        ext = {{POS_W{1'b0}}, cnt};
        return ext[POS_W-1:0];
    endfunction

endpackage

// ----- hdl/telnet_option_line_parser.sv -----
`timescale 1ns / 1ps
// each accepted input beat gives its result beat on the master side in the next cycle
// throughput: one byte per cycle unless stalled; a single registered parser step
// the output register lets a new byte in while the previous result is taken
// reset (synchronous, active low): parser in normal state, no cr seen, empty line,
// accepted options back to 3 and 1, no result pending
module telnet_option_line_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // received byte stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [7:0]                      i_s_tdata,   // [7:0] data_byte
    // result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [0] reply_valid, [1] reply_verb, [9:2] reply_option, [10] char_valid,
    // [18:11] char_value, [25:19] char_position, [26] line_overflow, [31:27] zero
    output logic [tolp_pkg::TDATA_W-1:0]    o_m_tdata,
    output logic                            o_m_tlast,   // line_end
    // register writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [7:0]                      i_cfg_index,
    input  logic [7:0]                      i_cfg_data
);
    import tolp_pkg::*;

    t_parse_state     r_state, n_state;
    logic             r_cr, n_cr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]       r_opt_a, r_opt_b;
    t_result          r_out, n_out;
    logic             r_out_valid;
    logic             s_fire;
    logic [7:0]       b;

    // output stage is free or being drained this cycle
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign s_fire      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign b           = i_s_tdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opt_a <= OPTION_A_RESET;
            r_opt_b <= OPTION_B_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_OPTION_A) begin
                r_opt_a <= i_cfg_data;
            end else if (i_cfg_index == CFG_OPTION_B) begin
                r_opt_b <= i_cfg_data;
            end
        end
    end

    // parser state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_NORMAL;
            r_cr    <= 1'b0;
            r_cnt   <= '0;
        end else if (s_fire) begin
            r_state <= n_state;
            r_cr    <= n_cr;
            r_cnt   <= n_cnt;
        end
    end

    // next state and result for the byte at the input
    always_comb begin
        n_state = ST_NORMAL;
        n_cr    = r_cr;
        n_cnt   = r_cnt;
        n_out   = '0;
        unique case (r_state)
            ST_IAC: begin
                // command byte after IAC; doubled IAC and unknown commands drop back
                priority if (b == CODE_WILL) begin
                    n_state = ST_WILL;
                end else if (b == CODE_WONT) begin
                    n_state = ST_WONT;
                end else if (b == CODE_DO) begin
                    n_state = ST_DO;
                end else if (b == CODE_DONT) begin
                    n_state = ST_DONT;
                end else begin
                    n_state = ST_NORMAL;
                end
            end
            ST_WILL, ST_WONT: begin
                n_out.reply_valid  = 1'b1;
                n_out.reply_verb   = VERB_DONT;
                n_out.reply_option = b;
            end
            ST_DO: begin
                // refuse unless the option is one we support
                if (b != r_opt_a && b != r_opt_b) begin
                    n_out.reply_valid  = 1'b1;
                    n_out.reply_verb   = VERB_WONT;
                    n_out.reply_option = b;
                end
            end
            ST_DONT: begin
                n_out.reply_valid  = 1'b1;
                n_out.reply_verb   = VERB_WONT;
                n_out.reply_option = b;
            end
            default: begin
                // normal state, unused codes fall in here too
                priority if (b == CODE_IAC) begin
                    n_state = ST_IAC;
                end else if (b == CODE_NUL) begin
                    // null bytes are ignored entirely
                end else if (b == CODE_CR) begin
                    n_cr                = 1'b1;
                    n_out.char_valid    = 1'b1;
                    n_out.char_position = pos_of(r_cnt);
                    n_out.line_end      = 1'b1;
                    n_cnt               = '0;
                end else if (b == CODE_LF) begin
                    if (r_cr) begin
                        // second half of cr lf, swallowed
                        n_cr = 1'b0;
                    end else begin
                        n_out.char_valid    = 1'b1;
                        n_out.char_position = pos_of(r_cnt);
                        n_out.line_end      = 1'b1;
                        n_cnt               = '0;
                    end
                end else begin
                    n_cr = 1'b0;
                    if (r_cnt < CNT_LAST) begin
                        n_out.char_valid    = 1'b1;
                        n_out.char_value    = b;
                        n_out.char_position = pos_of(r_cnt);
                        n_cnt               = r_cnt + CNT_W'(1);
                    end else begin
                        // line full, keep the slot for the terminator
                        n_out.line_overflow = 1'b1;
                    end
                end
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out.line_end;
    assign o_m_tdata  = {{(TDATA_W - 27){1'b0}}, r_out.line_overflow,
                         r_out.char_position, r_out.char_value, r_out.char_valid,
                         r_out.reply_option, r_out.reply_verb, r_out.reply_valid};

`ifndef SYNTH
    // a byte either answers a negotiation or goes to the line, never both
    a_reply_xor_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.reply_valid && r_out.char_valid))
        else $error("reply and character in the same beat");

    // line end always carries the terminating zero
    a_line_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.line_end) |-> (r_out.char_valid && r_out.char_value == CODE_NUL))
        else $error("line end without terminating zero");

    // the count never passes the terminator slot
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_LAST)
        else $error("line count past limit");

    // the byte after IAC produces no output
    a_iac_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && r_state == ST_IAC) |=> (r_out == '0))
        else $error("output on command byte");

    // negotiation bytes leave the line state alone
    a_neg_keeps_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && r_state != ST_NORMAL) |=> (r_cnt == $past(r_cnt) && r_cr == $past(r_cr)))
        else $error("negotiation byte changed line state");
`endif

endmodule
